// ----- rtl/emi_pkg.sv -----
`default_nettype none
package emi_pkg;

  localparam int unsigned LIMIT_W = 31;
  localparam logic [LIMIT_W-1:0] NO_CLAMP = {LIMIT_W{1'b1}};

  localparam int unsigned REG_SPEED_LIMIT = 0;
  localparam int unsigned REG_SPIN_LIMIT  = 1;

  // Sequencer states. Each vector step walks through these in order.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INTEG,
    ST_SQSUM,
    ST_SQRT,
    ST_CMP,
    ST_SCALE_MUL,
    ST_SCALE_DIV,
    ST_NEXT_VEC,
    ST_MOVE,
    ST_WRAP,
    ST_OUT
  } state_t;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INTEG_RATE,
    OP_SQSUM,
    OP_SQRT_START,
    OP_SCALE_MUL,
    OP_DIV_START,
    OP_DIV_STORE,
    OP_MOVE,
    OP_WRAP_START,
    OP_WRAP_STORE,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       vsel;   // 0 linear, 1 angular
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;         // an iterative unit is running
    logic need_clamp;   // length exceeds the selected limit
    logic out_free;     // output register can take a new result
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/emi_ctrl.sv -----
`default_nettype none
module emi_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_go,
  input  wire emi_pkg::dp_sts_t   sts,
  output emi_pkg::dp_cmd_t        cmd,
  output logic                    idle
);

  emi_pkg::state_t state_r, state_nxt;
  logic       vsel_r, vsel_nxt;
  logic [1:0] axis_r, axis_nxt;

  // The divide and wrap states alternate: start the unit, then store once it is done.
  logic wrap_run_r, wrap_run_nxt;
  logic div_run_r, div_run_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= emi_pkg::ST_IDLE;
      vsel_r  <= 1'b0;
      axis_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      vsel_r  <= vsel_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    vsel_nxt  = vsel_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      emi_pkg::ST_IDLE: begin
        if (in_go) begin
          state_nxt = emi_pkg::ST_INTEG;
          vsel_nxt  = 1'b0;
          axis_nxt  = 2'd0;
        end
      end
      emi_pkg::ST_INTEG: state_nxt = emi_pkg::ST_SQSUM;
      emi_pkg::ST_SQSUM: begin
        if (axis_r == 2'd2) begin
          axis_nxt  = 2'd0;
          state_nxt = emi_pkg::ST_SQRT;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      emi_pkg::ST_SQRT: state_nxt = emi_pkg::ST_CMP;
      emi_pkg::ST_CMP: begin
        if (!sts.busy) begin
          state_nxt = sts.need_clamp ? emi_pkg::ST_SCALE_MUL : emi_pkg::ST_NEXT_VEC;
        end
      end
      emi_pkg::ST_SCALE_MUL: state_nxt = emi_pkg::ST_SCALE_DIV;
      emi_pkg::ST_SCALE_DIV: begin
        if (div_run_r && !sts.busy) begin
          if (axis_r == 2'd2) begin
            axis_nxt  = 2'd0;
            state_nxt = emi_pkg::ST_NEXT_VEC;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = emi_pkg::ST_SCALE_MUL;
          end
        end
      end
      emi_pkg::ST_NEXT_VEC: begin
        axis_nxt = 2'd0;
        if (vsel_r) begin
          state_nxt = emi_pkg::ST_MOVE;
        end else begin
          vsel_nxt  = 1'b1;
          state_nxt = emi_pkg::ST_INTEG;
        end
      end
      emi_pkg::ST_MOVE: state_nxt = emi_pkg::ST_WRAP;
      emi_pkg::ST_WRAP: begin
        if (wrap_run_r && !sts.busy) begin
          if (axis_r == 2'd2) begin
            axis_nxt  = 2'd0;
            state_nxt = emi_pkg::ST_OUT;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end
      end
      emi_pkg::ST_OUT: begin
        if (sts.out_free) state_nxt = emi_pkg::ST_IDLE;
      end
      default: state_nxt = emi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_run_r <= 1'b0;
      div_run_r  <= 1'b0;
    end else begin
      wrap_run_r <= wrap_run_nxt;
      div_run_r  <= div_run_nxt;
    end
  end

  always_comb begin
    cmd.op       = emi_pkg::OP_NONE;
    cmd.vsel     = vsel_r;
    cmd.axis     = axis_r;
    idle         = 1'b0;
    wrap_run_nxt = wrap_run_r;
    div_run_nxt  = div_run_r;
    unique case (state_r)
      emi_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (in_go) cmd.op = emi_pkg::OP_LOAD;
      end
      emi_pkg::ST_INTEG: cmd.op = emi_pkg::OP_INTEG_RATE;
      emi_pkg::ST_SQSUM: cmd.op = emi_pkg::OP_SQSUM;
      emi_pkg::ST_SQRT:  cmd.op = emi_pkg::OP_SQRT_START;
      emi_pkg::ST_SCALE_MUL: begin
        cmd.op      = emi_pkg::OP_SCALE_MUL;
        div_run_nxt = 1'b0;
      end
      emi_pkg::ST_SCALE_DIV: begin
        if (!div_run_r) begin
          cmd.op      = emi_pkg::OP_DIV_START;
          div_run_nxt = 1'b1;
        end else if (!sts.busy) begin
          cmd.op      = emi_pkg::OP_DIV_STORE;
          div_run_nxt = 1'b0;
        end
      end
      emi_pkg::ST_MOVE: cmd.op = emi_pkg::OP_MOVE;
      emi_pkg::ST_WRAP: begin
        if (!wrap_run_r) begin
          cmd.op       = emi_pkg::OP_WRAP_START;
          wrap_run_nxt = 1'b1;
        end else if (!sts.busy) begin
          cmd.op       = emi_pkg::OP_WRAP_STORE;
          wrap_run_nxt = 1'b0;
        end
      end
      emi_pkg::ST_OUT: begin
        if (sts.out_free) cmd.op = emi_pkg::OP_OUT_LOAD;
      end
      default: cmd.op = emi_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/emi_dp.sv -----
`default_nettype none
module emi_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire emi_pkg::dp_cmd_t               cmd,
  output emi_pkg::dp_sts_t                    sts,
  input  wire logic [15:0]                    in_delta_time,
  input  wire logic signed [31:0]             in_accel_x,
  input  wire logic signed [31:0]             in_accel_y,
  input  wire logic signed [31:0]             in_accel_z,
  input  wire logic signed [31:0]             in_spin_accel_x,
  input  wire logic signed [31:0]             in_spin_accel_y,
  input  wire logic signed [31:0]             in_spin_accel_z,
  input  wire logic [emi_pkg::LIMIT_W-1:0]    speed_limit,
  input  wire logic [emi_pkg::LIMIT_W-1:0]    spin_limit,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [31:0]                  out_pos_x,
  output logic signed [31:0]                  out_pos_y,
  output logic signed [31:0]                  out_pos_z,
  output logic signed [19:0]                  out_angle_x,
  output logic signed [19:0]                  out_angle_y,
  output logic signed [19:0]                  out_angle_z
);

  // 2*pi at FRAC_BITS fraction bits, rounded to nearest, from a Q48 value.
  localparam logic [63:0] TWO_PI_Q48 = 64'h0006487ED5110B46;
  localparam logic [63:0] TWO_PI_R =
      (TWO_PI_Q48 + (64'd1 << (47 - FRAC_BITS))) >> (48 - FRAC_BITS);
  localparam logic [31:0] TWO_PI = TWO_PI_R[31:0];
  // floor(2^32 / 2*pi): the quotient estimate is low by at most one.
  localparam logic [63:0] RECIP_R = (64'd1 << 32) / TWO_PI_R;
  localparam logic [31:0] TWO_PI_RECIP = RECIP_R[31:0];

  logic signed [31:0] vel_r [3];
  logic signed [31:0] spn_r [3];
  logic signed [31:0] pos_r [3];
  logic signed [31:0] rot_r [3];
  logic signed [31:0] lin_acc_r [3];
  logic signed [31:0] ang_acc_r [3];
  logic [15:0] dt_r;

  logic [65:0] sum_r;
  logic [31:0] len_r;
  logic [62:0] prod_r;

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [47:0] p);
    logic signed [47:0] inc;
    logic signed [48:0] s;
    begin
      inc = p >>> FRAC_BITS;
      s = 49'(a) + 49'(inc);
      if (s > 49'sd2147483647) add_sat = 32'sh7FFFFFFF;
      else if (s < -49'sd2147483648) add_sat = 32'sh80000000;
      else add_sat = s[31:0];
    end
  endfunction

  logic signed [31:0] cur_v;
  logic [31:0] cur_mag;
  logic [30:0] cur_lim;
  always_comb begin
    cur_v   = cmd.vsel ? spn_r[cmd.axis] : vel_r[cmd.axis];
    cur_mag = cur_v[31] ? 32'(-cur_v) : 32'(cur_v);
    cur_lim = cmd.vsel ? spin_limit : speed_limit;
  end

  // Shared multi-cycle units: square root and restoring divider.
  logic        sq_busy_r;
  logic [65:0] sq_rem_r;
  logic [32:0] sq_root_r;
  logic [5:0]  sq_cnt_r;

  logic        dv_busy_r;
  logic [63:0] dv_num_r;
  logic [32:0] dv_rem_r;
  logic [31:0] dv_den_r;
  logic [6:0]  dv_cnt_r;
  logic        dv_neg_r;

  // Rotation wrap: reciprocal multiply, back-multiply and subtract, then one
  // conditional subtract of 2*pi at the store.
  logic [1:0]  wr_cnt_r;
  logic [31:0] wr_mag_r;
  logic [31:0] wr_q_r;
  logic [31:0] wr_rem_r;
  logic        wr_neg_r;
  logic [63:0] wr_prod;
  logic [31:0] wr_fix;
  always_comb begin
    wr_prod = {32'd0, wr_mag_r} * {32'd0, TWO_PI_RECIP};
    wr_fix  = (wr_rem_r >= TWO_PI) ? wr_rem_r - TWO_PI : wr_rem_r;
  end

  logic [67:0] sq_trial;
  logic [66:0] sq_remsh;
  always_comb begin
    sq_remsh = {sq_rem_r[64:0], sum_r[65:64]};
    sq_trial = {1'b0, sq_remsh} - {33'd0, sq_root_r, 2'b01};
  end

  logic [33:0] dv_sh;
  logic [33:0] dv_diff;
  always_comb begin
    dv_sh   = {dv_rem_r, dv_num_r[63]};
    dv_diff = dv_sh - {2'b00, dv_den_r};
  end

  logic out_valid_r;
  logic signed [31:0] o_pos_r [3];
  logic signed [19:0] o_ang_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        vel_r[i] <= '0;
        spn_r[i] <= '0;
        pos_r[i] <= '0;
        rot_r[i] <= '0;
      end
      sq_busy_r   <= 1'b0;
      dv_busy_r   <= 1'b0;
      wr_cnt_r    <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == emi_pkg::OP_OUT_LOAD) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      if (sq_busy_r) begin
        if (!sq_trial[67]) begin
          sq_rem_r  <= sq_trial[65:0];
          sq_root_r <= {sq_root_r[31:0], 1'b1};
        end else begin
          sq_rem_r  <= sq_remsh[65:0];
          sq_root_r <= {sq_root_r[31:0], 1'b0};
        end
        sum_r    <= {sum_r[63:0], 2'b00};
        sq_cnt_r <= sq_cnt_r - 6'd1;
        if (sq_cnt_r == 6'd1) sq_busy_r <= 1'b0;
      end

      if (dv_busy_r) begin
        if (!dv_diff[33]) begin
          dv_rem_r <= dv_diff[32:0];
          dv_num_r <= {dv_num_r[62:0], 1'b1};
        end else begin
          dv_rem_r <= dv_sh[32:0];
          dv_num_r <= {dv_num_r[62:0], 1'b0};
        end
        dv_cnt_r <= dv_cnt_r - 7'd1;
        if (dv_cnt_r == 7'd1) dv_busy_r <= 1'b0;
      end

      if (wr_cnt_r == 2'd2) begin
        wr_q_r   <= wr_prod[63:32];
        wr_cnt_r <= 2'd1;
      end else if (wr_cnt_r == 2'd1) begin
        wr_rem_r <= wr_mag_r - wr_q_r * TWO_PI;
        wr_cnt_r <= 2'd0;
      end

      case (cmd.op)
        emi_pkg::OP_LOAD: begin
          dt_r         <= in_delta_time;
          lin_acc_r[0] <= in_accel_x;
          lin_acc_r[1] <= in_accel_y;
          lin_acc_r[2] <= in_accel_z;
          ang_acc_r[0] <= in_spin_accel_x;
          ang_acc_r[1] <= in_spin_accel_y;
          ang_acc_r[2] <= in_spin_accel_z;
        end
        emi_pkg::OP_INTEG_RATE: begin
          for (int i = 0; i < 3; i++) begin
            if (cmd.vsel) spn_r[i] <= add_sat(spn_r[i],
                48'(ang_acc_r[i]) * $signed({32'd0, dt_r}));
            else vel_r[i] <= add_sat(vel_r[i],
                48'(lin_acc_r[i]) * $signed({32'd0, dt_r}));
          end
          sum_r <= '0;
        end
        emi_pkg::OP_SQSUM: sum_r <= sum_r + 66'(64'(cur_mag) * 64'(cur_mag));
        emi_pkg::OP_SQRT_START: begin
          sq_busy_r <= 1'b1;
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          sq_cnt_r  <= 6'd33;
        end
        emi_pkg::OP_SCALE_MUL: prod_r <= 63'(cur_mag) * 63'(cur_lim);
        emi_pkg::OP_DIV_START: begin
          dv_busy_r <= 1'b1;
          dv_num_r  <= {1'b0, prod_r};
          dv_rem_r  <= '0;
          dv_den_r  <= len_r;
          dv_cnt_r  <= 7'd64;
          dv_neg_r  <= cur_v[31];
        end
        emi_pkg::OP_DIV_STORE: begin
          if (cmd.vsel) spn_r[cmd.axis] <= dv_neg_r ? -dv_num_r[31:0] : dv_num_r[31:0];
          else vel_r[cmd.axis] <= dv_neg_r ? -dv_num_r[31:0] : dv_num_r[31:0];
        end
        emi_pkg::OP_MOVE: begin
          for (int i = 0; i < 3; i++) begin
            pos_r[i] <= add_sat(pos_r[i], 48'(vel_r[i]) * $signed({32'd0, dt_r}));
            rot_r[i] <= add_sat(rot_r[i], 48'(spn_r[i]) * $signed({32'd0, dt_r}));
          end
        end
        emi_pkg::OP_WRAP_START: begin
          wr_cnt_r <= 2'd2;
          wr_mag_r <= rot_r[cmd.axis][31] ? 32'(-rot_r[cmd.axis])
                                          : 32'(rot_r[cmd.axis]);
          wr_neg_r <= rot_r[cmd.axis][31];
        end
        emi_pkg::OP_WRAP_STORE:
          rot_r[cmd.axis] <= wr_neg_r ? -wr_fix : wr_fix;
        emi_pkg::OP_OUT_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            o_pos_r[i] <= pos_r[i];
            o_ang_r[i] <= rot_r[i][19:0];
          end
        end
        default: ;
      endcase

      if (sq_busy_r && sq_cnt_r == 6'd1)
        len_r <= (!sq_trial[67]) ? {sq_root_r[30:0], 1'b1} : {sq_root_r[30:0], 1'b0};
    end
  end

  always_comb begin
    sts.busy       = sq_busy_r | dv_busy_r | (wr_cnt_r != 2'd0);
    sts.need_clamp = (cur_lim != emi_pkg::NO_CLAMP) && (len_r > {1'b0, cur_lim});
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = o_pos_r[0];
  assign out_pos_y   = o_pos_r[1];
  assign out_pos_z   = o_pos_r[2];
  assign out_angle_x = o_ang_r[0];
  assign out_angle_y = o_ang_r[1];
  assign out_angle_z = o_ang_r[2];

endmodule
`default_nettype wire

// ----- rtl/euler_motion_integrator_unit.sv -----
`default_nettype none
// Semi-implicit Euler integrator for one rigid body in Q16.16 fixed point.
// Each input transaction is one tick: velocity and spin rate gain their
// accelerations times the time step, each vector is clamped to its terminal
// length (speed_limit, spin_limit; all ones disables a clamp), then position
// and rotation integrate and rotation is wrapped modulo 2*pi. One result
// transaction follows each tick. How long a tick runs depends on how many
// vectors are clamped and on how long the previous result is stalled. It is
// set by the shared bit-serial square root (one run per vector), the shared
// restoring divider (one run per clamped component), the reciprocal wrap per
// rotation axis, and the sequencer that runs them. Input is taken only while
// the block is idle; the output register lets the next tick start while a
// result waits.
// Limits are written over the APB port at byte addresses 0 and 4.
module euler_motion_integrator_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        in_delta_time,
  input  wire logic signed [31:0] in_accel_x,
  input  wire logic signed [31:0] in_accel_y,
  input  wire logic signed [31:0] in_accel_z,
  input  wire logic signed [31:0] in_spin_accel_x,
  input  wire logic signed [31:0] in_spin_accel_y,
  input  wire logic signed [31:0] in_spin_accel_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [19:0]      out_angle_x,
  output logic signed [19:0]      out_angle_y,
  output logic signed [19:0]      out_angle_z,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [2:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  logic [emi_pkg::LIMIT_W-1:0] speed_limit_r, spin_limit_r;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  // Register writes; addresses beyond the two limits are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r <= emi_pkg::NO_CLAMP;
      spin_limit_r  <= emi_pkg::NO_CLAMP;
    end else if (wr_en) begin
      if (cfg_paddr == 3'(4 * emi_pkg::REG_SPEED_LIMIT))
        speed_limit_r <= cfg_pwdata[emi_pkg::LIMIT_W-1:0];
      else if (cfg_paddr == 3'(4 * emi_pkg::REG_SPIN_LIMIT))
        spin_limit_r <= cfg_pwdata[emi_pkg::LIMIT_W-1:0];
    end
  end

  always_comb begin
    if (cfg_paddr == 3'(4 * emi_pkg::REG_SPEED_LIMIT)) cfg_prdata = {1'b0, speed_limit_r};
    else if (cfg_paddr == 3'(4 * emi_pkg::REG_SPIN_LIMIT)) cfg_prdata = {1'b0, spin_limit_r};
    else cfg_prdata = 32'd0;
  end

  emi_pkg::dp_cmd_t cmd;
  emi_pkg::dp_sts_t sts;
  logic idle;

  assign in_stall = !idle;

  emi_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_go (in_valid && idle),
    .sts   (sts),
    .cmd   (cmd),
    .idle  (idle)
  );

  emi_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_delta_time   (in_delta_time),
    .in_accel_x      (in_accel_x),
    .in_accel_y      (in_accel_y),
    .in_accel_z      (in_accel_z),
    .in_spin_accel_x (in_spin_accel_x),
    .in_spin_accel_y (in_spin_accel_y),
    .in_spin_accel_z (in_spin_accel_z),
    .speed_limit     (speed_limit_r),
    .spin_limit      (spin_limit_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_angle_x     (out_angle_x),
    .out_angle_y     (out_angle_y),
    .out_angle_z     (out_angle_z)
  );

endmodule
`default_nettype wire

// ----- bench/euler_motion_integrator_unit_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
// Checks the motion integrator tick by tick against a behavioral copy of the
// integrator held in this bench. Each input transaction updates the bench's
// copy of the body state; the result transaction that follows must match it.
module euler_motion_integrator_unit_test;

  localparam int FRAC = 16;
  localparam longint TWO_PI_FIX = 411775;
  localparam logic [30:0] MAX_LIMIT = 31'h7FFFFFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_delta_time = '0;
  logic signed [31:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic signed [31:0] in_spin_accel_x = '0, in_spin_accel_y = '0, in_spin_accel_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [19:0] out_angle_x, out_angle_y, out_angle_z;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  euler_motion_integrator_unit uut (.*);

  // One expected result: three positions and three wrapped angles.
  typedef struct {
    logic signed [31:0] pos[3];
    logic signed [19:0] ang[3];
  } pose_t;

  pose_t expected_poses[$];

  // The bench's own copy of the body state and the two limits.
  logic signed [31:0] lin_vel[3], ang_vel[3], body_pos[3], body_rot[3];
  logic [30:0] speed_cap = MAX_LIMIT, spin_cap = MAX_LIMIT;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int errors = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // A generous fixed ceiling. Even with the slowest ticks and the heaviest
  // receiver stalls the whole run stays well below this.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Accumulate rate*dt into an accumulator. The product shift floors, and
  // the sum saturates to 32 bits.
  function automatic logic signed [31:0] accumulate(logic signed [31:0] acc,
                                                    logic signed [31:0] rate,
                                                    logic [15:0] dt);
    longint prod, sum;
    prod = longint'(rate) * longint'({1'b0, dt});
    sum = longint'(acc) + (prod >>> FRAC);
    if (sum > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (sum < -64'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Rescale a vector to the limit when its length is above it.
  task automatic limit_length(ref logic signed [31:0] v[3], input logic [30:0] cap);
    longint unsigned sum, len, mag, q;
    sum = 0;
    if (cap == MAX_LIMIT) return;
    for (int i = 0; i < 3; i++) begin
      mag = (v[i] < 0) ? longint'(-longint'(v[i])) : longint'(v[i]);
      sum += mag * mag;
    end
    len = floor_sqrt(sum);
    if (len <= cap) return;
    for (int i = 0; i < 3; i++) begin
      mag = (v[i] < 0) ? longint'(-longint'(v[i])) : longint'(v[i]);
      q = (mag * longint'(cap)) / len;
      v[i] = (v[i] < 0) ? -q[31:0] : q[31:0];
    end
  endtask

  // Advance the bench's body state by one tick and queue the pose it gives.
  task automatic predict_tick(logic [15:0] dt, logic signed [31:0] acc[3],
                              logic signed [31:0] sacc[3]);
    pose_t p;
    longint r;
    for (int i = 0; i < 3; i++) lin_vel[i] = accumulate(lin_vel[i], acc[i], dt);
    limit_length(lin_vel, speed_cap);
    for (int i = 0; i < 3; i++) ang_vel[i] = accumulate(ang_vel[i], sacc[i], dt);
    limit_length(ang_vel, spin_cap);
    for (int i = 0; i < 3; i++) begin
      body_pos[i] = accumulate(body_pos[i], lin_vel[i], dt);
      body_rot[i] = accumulate(body_rot[i], ang_vel[i], dt);
      // SystemVerilog % truncates toward zero, so the sign follows the dividend.
      r = longint'(body_rot[i]) % TWO_PI_FIX;
      body_rot[i] = r[31:0];
      p.pos[i] = body_pos[i];
      p.ang[i] = r[19:0];
    end
    expected_poses.push_back(p);
  endtask

  // Send one tick transaction, idling at random before it, and predict it.
  // The block stalls its input while it works on each tick, so dropping valid
  // after acceptance costs nothing.
  task automatic send_tick(logic [15:0] dt, logic signed [31:0] acc[3],
                           logic signed [31:0] sacc[3]);
    while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_delta_time <= dt;
    in_accel_x <= acc[0];
    in_accel_y <= acc[1];
    in_accel_z <= acc[2];
    in_spin_accel_x <= sacc[0];
    in_spin_accel_y <= sacc[1];
    in_spin_accel_z <= sacc[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tick(dt, acc, sacc);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers are written only once the block has drained.
  task automatic write_limit(int unsigned idx, logic [31:0] value);
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 3'(4 * idx);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == emi_pkg::REG_SPEED_LIMIT) speed_cap = value[30:0];
    else if (idx == emi_pkg::REG_SPIN_LIMIT) spin_cap = value[30:0];
  endtask

  function automatic logic signed [31:0] random_word();
    return $urandom();
  endfunction

  // Random acceleration, mostly modest so the state does not sit in
  // saturation, with a share of full-range values.
  function automatic logic signed [31:0] random_accel();
    case ($urandom_range(3))
      0: return random_word();
      1: return $signed($urandom_range(32'h7FFFF)) - 32'sh3FFFF;
      default: return $signed($urandom_range(32'h7FFFFF)) - 32'sh3FFFFF;
    endcase
  endfunction

  task automatic random_ticks(int count);
    logic signed [31:0] a[3], s[3];
    logic [15:0] dt;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = random_accel();
        s[i] = random_accel();
      end
      case ($urandom_range(5))
        0: dt = 16'($urandom());
        1: dt = 16'd0;
        default: dt = 16'($urandom_range(16'h0FFF));
      endcase
      send_tick(dt, a, s);
    end
  endtask

  // Directed ticks: field extremes, zero and full time step, and zero
  // accelerations.
  task automatic test_extremes();
    logic signed [31:0] a[3], s[3];
    a = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0};
    s = '{32'sh80000000, 32'sh7FFFFFFF, 32'sd65536};
    send_tick(16'hFFFF, a, s);
    send_tick(16'hFFFF, a, s);
    send_tick(16'd0, a, s);
    a = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
    s = '{32'sd1, -32'sd1, 32'sh7FFFFFFF};
    send_tick(16'h8000, a, s);
    send_tick(16'd1, a, s);
    a = '{32'sd0, 32'sd0, 32'sd0};
    s = '{32'sd0, 32'sd0, 32'sd0};
    send_tick(16'd0, a, s);
    send_tick(16'hFFFF, a, s);
  endtask

  task automatic test_clamps();
    logic signed [31:0] a[3], s[3];
    write_limit(emi_pkg::REG_SPEED_LIMIT, 32'h0);
    write_limit(emi_pkg::REG_SPIN_LIMIT, 32'h0);
    a = '{32'sd65536, -32'sd131072, 32'sd7};
    s = '{-32'sd3, 32'sd400000, 32'sd0};
    send_tick(16'd65535, a, s);
    send_tick(16'd100, a, s);
    write_limit(emi_pkg::REG_SPEED_LIMIT, 32'h0001_0000);
    write_limit(emi_pkg::REG_SPIN_LIMIT, 32'hFFFF_FFFE);
    send_tick(16'd4096, a, s);
    send_tick(16'd65535, a, s);
    write_limit(emi_pkg::REG_SPEED_LIMIT, 32'h7FFF_FFFE);
    write_limit(emi_pkg::REG_SPIN_LIMIT, 32'h0000_8000);
    send_tick(16'd65535, s, a);
    send_tick(16'd2, a, s);
    write_limit(emi_pkg::REG_SPEED_LIMIT, 32'hFFFF_FFFF);
    write_limit(emi_pkg::REG_SPIN_LIMIT, 32'h7FFF_FFFF);
    send_tick(16'd65535, a, s);
  endtask

  // Random ticks under a mix of limit settings, each idling pattern in turn.
  task automatic test_random();
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 87 : 0;
      receiver_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 21 : 0;
      for (int k = 0; k < 3; k++) begin
        write_limit(emi_pkg::REG_SPEED_LIMIT,
                    (k == 0) ? 32'h7FFFFFFF : $urandom_range(32'h3FFFFF));
        write_limit(emi_pkg::REG_SPIN_LIMIT,
                    (k == 2) ? 32'h7FFFFFFF : $urandom_range(32'h3FFFFF));
        random_ticks(120);
      end
    end
  endtask

  // Receiver side: stall at random and compare each accepted pose.
  always @(posedge clk) begin
    pose_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_poses.size() == 0) begin
        $error("result transaction with no tick outstanding");
        errors++;
      end else begin
        e = expected_poses.pop_front();
        if (out_pos_x !== e.pos[0]) begin
          $error("pos_x expected %0d got %0d", e.pos[0], out_pos_x); errors++;
        end
        if (out_pos_y !== e.pos[1]) begin
          $error("pos_y expected %0d got %0d", e.pos[1], out_pos_y); errors++;
        end
        if (out_pos_z !== e.pos[2]) begin
          $error("pos_z expected %0d got %0d", e.pos[2], out_pos_z); errors++;
        end
        if (out_angle_x !== e.ang[0]) begin
          $error("angle_x expected %0d got %0d", e.ang[0], out_angle_x); errors++;
        end
        if (out_angle_y !== e.ang[1]) begin
          $error("angle_y expected %0d got %0d", e.ang[1], out_angle_y); errors++;
        end
        if (out_angle_z !== e.ang[2]) begin
          $error("angle_z expected %0d got %0d", e.ang[2], out_angle_z); errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  initial begin
    for (int i = 0; i < 3; i++) begin
      lin_vel[i] = '0;
      ang_vel[i] = '0;
      body_pos[i] = '0;
      body_rot[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_clamps();
    test_random();
    // Drain: wait for every pose, then allow one slow tick's worth of cycles.
    while (expected_poses.size() != 0) @(posedge clk);
    receiver_idle_pct = 0;
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
